// ----- design/tss_pkg.sv -----
package tss_pkg;

  // Series length
  localparam int MAX_ORDER = 16;
  localparam int N_W       = $clog2(MAX_ORDER + 1);

  // Argument and result formats
  localparam int X_W      = 16;
  localparam int X_FRAC   = 12;
  localparam int AX_W     = 16;
  localparam int RES_W    = 32;
  localparam int RES_FRAC = 16;

  // Term magnitudes are Q.32; the largest term for |x| <= 8 stays below 2^41
  localparam int SUM_FRAC = 32;
  localparam int M_W      = 42;
  localparam int SUM_W    = 48;
  localparam int PROD_W   = M_W + AX_W;

  // Divide by n: one 8-bit quotient digit per cycle
  localparam int DIGIT     = 8;
  localparam int DIV_STEPS = (PROD_W - X_FRAC + DIGIT - 1) / DIGIT;
  localparam int DVD_W     = DIV_STEPS * DIGIT;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration registers
  localparam int FS_W       = 2;
  localparam int HP_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_POWER   = 2'd1;

  localparam logic [FS_W-1:0] FUNC_SIN = 2'd0;
  localparam logic [FS_W-1:0] FUNC_COS = 2'd1;
  localparam logic [FS_W-1:0] FUNC_EXP = 2'd2;

  localparam logic [FS_W-1:0] FS_RESET = FUNC_SIN;
  localparam logic [HP_W-1:0] HP_RESET = 5'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WAIT,
    ST_FINAL
  } state_t;

endpackage

// ----- design/tss_if.sv -----
interface tss_in_if;
  import tss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

interface tss_out_if;
  import tss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] approximation;
  logic                    saturated;
  modport source (output valid, output approximation, output saturated, input ready);
  modport sink   (input valid, input approximation, input saturated, output ready);
endinterface

interface tss_cfg_if;
  import tss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/tss_term_unit.sv -----
module tss_term_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [tss_pkg::M_W-1:0]  m,
  input  logic [tss_pkg::AX_W-1:0] ax,
  input  logic [tss_pkg::N_W-1:0]  n,
  output logic                   done,
  output logic [tss_pkg::M_W-1:0]  q
);
  import tss_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DVD_W-1:0]  work;
  logic [DVD_W-1:0]  work_next;
  logic [N_W-1:0]    rem;
  logic [N_W-1:0]    rem_next;
  logic [PROD_W-1:0] product;

  assign product = PROD_W'(m) * PROD_W'(ax);

  // Restoring long division, DIGIT quotient bits per cycle; quotient bits shift in at the bottom
  always_comb begin
    logic [N_W:0]     t;
    logic [N_W-1:0]   r;
    logic [DVD_W-1:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < DIGIT; i++) begin
      t = {r, w[DVD_W-1]};
      w = {w[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, n}) begin
        t    = t - {1'b0, n};
        w[0] = 1'b1;
      end
      r = t[N_W-1:0];
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load the product scaled down by the argument's fraction bits, then divide by n
  always_ff @(posedge clk) begin
    if (start) begin
      work <= DVD_W'(product >> X_FRAC);
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign q = work[M_W-1:0];

endmodule

// ----- design/taylor_series_sin_cos_exp.sv -----
// Each argument runs T terms in turn, then its result is loaded into the output register,
//   T = clamped highest_power minus the first power (1 for sine, 0 otherwise), at least 0.
// Each term runs on the shared term unit: a 42x16 multiply loaded at start,
//   six 8-bit quotient-digit steps of the divide by n, one accumulate.
// New arguments wait until the last result is loaded (T = 0 for an unused selector).
// Reset (rst, synchronous high): function_select sine, highest_power 7, no result pending.
module taylor_series_sin_cos_exp (
  input logic clk,
  input logic rst,
  tss_cfg_if.sink   cfg,
  tss_in_if.sink    arg,
  tss_out_if.source result
);
  import tss_pkg::*;

  localparam logic [M_W-1:0]   ONE_TERM   = M_W'(1) << SUM_FRAC;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (SUM_FRAC - RES_FRAC - 1);
  localparam logic [SUM_W-1:0] POS_MAG    = SUM_W'((64'd1 << (RES_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] NEG_MAG    = SUM_W'(64'd1 << (RES_W - 1));

  state_t state;
  state_t state_next;

  logic [FS_W-1:0]  func_sel;
  logic [HP_W-1:0]  high_pow;

  logic             xneg;
  logic [AX_W-1:0]  ax;
  logic [FS_W-1:0]  sel_r;
  logic [N_W-1:0]   hp_r;
  logic [N_W-1:0]   n;
  logic [M_W-1:0]   m;
  logic [SUM_W-1:0] sum;

  logic             out_valid;
  logic [RES_W-1:0] approx_r;
  logic             sat_r;

  logic             term_start;
  logic             term_done;
  logic [M_W-1:0]   term_q;
  logic             out_load;

  // Values taken at the argument transfer
  logic             xneg_in;
  logic [AX_W-1:0]  ax_in;
  logic [N_W-1:0]   hp_in;
  logic [N_W-1:0]   n0;
  logic             sel_valid;
  logic             first_final;
  logic [M_W-1:0]   m_init;
  logic [SUM_W-1:0] sum_init;

  logic             use_term;
  logic             tneg;
  logic [SUM_W-1:0] term_ext;
  logic [SUM_W-1:0] sum_acc;

  logic             sum_neg;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] rnd;
  logic [SUM_W-1:0] clip;
  logic             sat_val;
  logic [SUM_W-1:0] res_full;

  tss_term_unit u_term (
    .clk   (clk),
    .rst   (rst),
    .start (term_start),
    .m     (m),
    .ax    (ax),
    .n     (n),
    .done  (term_done),
    .q     (term_q)
  );

  // Configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_sel <= FS_RESET;
      high_pow <= HP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FUNCTION_SELECT: func_sel <= cfg.data[FS_W-1:0];
        REG_HIGHEST_POWER:   high_pow <= cfg.data[HP_W-1:0];
        default: ;
      endcase
    end
  end

  // Argument setup
  always_comb begin
    xneg_in   = arg.x_value[X_W-1];
    ax_in     = xneg_in ? AX_W'(-arg.x_value) : AX_W'(arg.x_value);
    hp_in     = (high_pow > HP_W'(MAX_ORDER)) ? N_W'(MAX_ORDER) : N_W'(high_pow);
    n0        = (func_sel == FUNC_SIN) ? N_W'(2) : N_W'(1);
    sel_valid = (func_sel == FUNC_SIN) || (func_sel == FUNC_COS) || (func_sel == FUNC_EXP);
    first_final = !sel_valid || (n0 > hp_in);
    if (func_sel == FUNC_SIN) begin
      m_init   = M_W'(ax_in) << (SUM_FRAC - X_FRAC);
      sum_init = xneg_in ? (SUM_W'(0) - SUM_W'(m_init)) : SUM_W'(m_init);
    end else begin
      m_init   = ONE_TERM;
      sum_init = sel_valid ? SUM_W'(ONE_TERM) : '0;
    end
  end

  // Term sign and parity
  always_comb begin
    case (sel_r)
      FUNC_SIN: begin
        use_term = n[0];
        tneg     = xneg ^ n[1];
      end
      FUNC_COS: begin
        use_term = !n[0];
        tneg     = n[1];
      end
      default: begin
        use_term = 1'b1;
        tneg     = xneg & n[0];
      end
    endcase
    term_ext = SUM_W'(term_q);
    if (!use_term) begin
      sum_acc = sum;
    end else if (tneg) begin
      sum_acc = sum - term_ext;
    end else begin
      sum_acc = sum + term_ext;
    end
  end

  // Round the Q.32 magnitude half away from zero to Q15.16, then clip
  always_comb begin
    sum_neg = sum[SUM_W-1];
    mag     = sum_neg ? (SUM_W'(0) - sum) : sum;
    rnd     = (mag + ROUND_HALF) >> (SUM_FRAC - RES_FRAC);
    if (sum_neg) begin
      sat_val  = rnd > NEG_MAG;
      clip     = sat_val ? NEG_MAG : rnd;
      res_full = SUM_W'(0) - clip;
    end else begin
      sat_val  = rnd > POS_MAG;
      clip     = sat_val ? POS_MAG : rnd;
      res_full = clip;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    arg.ready  = 1'b0;
    term_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        arg.ready = 1'b1;
        if (arg.valid) begin
          state_next = first_final ? ST_FINAL : ST_MUL;
        end
      end
      ST_MUL: begin
        term_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (term_done) begin
          state_next = (n == hp_r) ? ST_FINAL : ST_MUL;
        end
      end
      ST_FINAL: begin
        // hold until the output register is free
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (arg.valid && arg.ready) begin
      xneg  <= xneg_in;
      ax    <= ax_in;
      sel_r <= func_sel;
      hp_r  <= hp_in;
      n     <= n0;
      m     <= m_init;
      sum   <= sum_init;
    end else if (state == ST_WAIT && term_done) begin
      m   <= term_q;
      sum <= sum_acc;
      n   <= n + 1'b1;
    end
    if (out_load) begin
      approx_r <= res_full[RES_W-1:0];
      sat_r    <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.approximation = approx_r;
  assign result.saturated     = sat_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    term_done |-> state == ST_WAIT)
    else $error("term unit finished outside the wait state");

  a_mul_then_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_WAIT)
    else $error("term start not followed by wait");

  a_n_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> (n <= hp_r && n != '0))
    else $error("term index outside the series");

  a_final_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && out_valid && !result.ready) |=> state == ST_FINAL)
    else $error("result overwritten before transfer");

endmodule
